// ===== sv/cbsp_pkg.sv =====
// Package for the cost bounded shortest path engine.
// Holds shared constants, the sequencer state type and the node record type.
// No dependencies.
package cbsp_pkg;
   localparam int NODE_COUNT_DEF    = 64;
   localparam int EDGE_CAPACITY_DEF = 1024;
   localparam int NODE_W = 6;
   localparam int COST_W = 16;
   localparam int DIST_W = 31;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic CSR_START_NODE = 1'b0;
   localparam logic CSR_MAX_COST   = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_SELECT,
      ST_SCAN,
      ST_RELAX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [NODE_W-1:0] prev;
      logic              has_prev;
      logic              reached;
      logic              settled;
   } node_type;
endpackage

// ===== sv/cost_bounded_shortest_paths.sv =====
// Cost bounded shortest path engine (Dijkstra with a cost limit).
// Usage:
//   Requests (req_*) carry one directed edge each and are taken when start
//   is high and busy is low. Edges load one per cycle into the edge store until it is full.
//   The request with req_last_edge set is stored too and starts the search
//   from the configured start node; busy drops as the final result appears.
//   Results (rsp_*) appear one per cycle, node 0 first, marked by rsp_valid;
//   rsp_last_result flags the final node. The receiver cannot stall.
// Phases:
//   Search = node clear, then a read of every node per selection; per
//   settled node a settle step and a scan end, a read of every stored edge
//   and a relax step per edge leaving it; then output, the first result
//   after the first node read and the rest back to back.
//   Selection and scanning are bounded by the single node-store read port.
// Reset:
//   Synchronous, active high. Clears the edge count and configuration
//   (start node 0, cost limit all ones). Node state is cleared at each run.
// The user must write configuration (csr_*) only while busy is low; the block does not enforce it.
module cost_bounded_shortest_paths import cbsp_pkg::*; #(
   parameter int NODE_COUNT    = NODE_COUNT_DEF,
   parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [NODE_W-1:0] req_edge_source,
   input  logic [NODE_W-1:0] req_edge_target,
   input  logic [COST_W-1:0] req_edge_cost,
   input  logic              req_last_edge,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [DIST_W-1:0] csr_data,
   output logic              rsp_valid,
   output logic [NODE_W-1:0] rsp_node_id,
   output logic [DIST_W-1:0] rsp_best_cost,
   output logic [NODE_W-1:0] rsp_previous_node,
   output logic              rsp_has_previous,
   output logic              rsp_reached,
   output logic              rsp_last_result
);
   localparam int AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
   localparam int CW = $clog2(EDGE_CAPACITY + 1);
   localparam int NW = $clog2(NODE_COUNT + 1);
   localparam logic [CW-1:0] CAP = CW'(EDGE_CAPACITY);
   localparam logic [NW-1:0] NCNT = NW'(NODE_COUNT);

   state_type state_ff, state_in;
   logic [NODE_W-1:0] start_node_ff;
   logic [DIST_W-1:0] max_cost_ff;
   logic [CW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0] eidx_ff, eidx_in;
   logic [NW-1:0] nidx_ff, nidx_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          found_ff, found_in;
   logic [NODE_W-1:0] best_ff, best_in;
   logic [DIST_W-1:0] bd_ff, bd_in;
   logic [NODE_W-1:0] tgt_ff, tgt_in;
   logic [DIST_W-1:0] sum_ff, sum_in;
   logic          out_valid_ff, out_valid_in;
   logic [NODE_W-1:0] out_id_ff, out_id_in;
   node_type      out_rec_ff, out_rec_in;
   logic          out_last_ff, out_last_in;

   logic e_wr;
   logic [AW-1:0] e_raddr;
   logic [2*NODE_W+COST_W-1:0] e_rdata;
   logic n_wr;
   logic [NODE_W-1:0] n_waddr, n_raddr;
   node_type n_wdata, n_rdata;

   logic accept;
   logic [NODE_W-1:0] e_src, e_tgt;
   logic [COST_W-1:0] e_cost;
   logic [DIST_W:0] sum_wide;
   logic [NODE_W-1:0] prev_n;
   logic front;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_LOAD);
   assign e_wr   = accept && (edge_count_ff < CAP);
   assign {e_src, e_tgt, e_cost} = e_rdata;
   assign prev_n = NODE_W'(nidx_ff - NW'(1));
   assign front  = ((prev_n == start_node_ff) || n_rdata.reached) && !n_rdata.settled;
   assign sum_wide = {1'b0, bd_ff} + (DIST_W+1)'(e_cost);

   cbsp_edge_mem #(.EDGE_CAPACITY(EDGE_CAPACITY), .AW(AW)) u_edge (
      .clock(clock), .wr_en(e_wr), .wr_addr(AW'(edge_count_ff)),
      .wr_data({req_edge_source, req_edge_target, req_edge_cost}),
      .rd_addr(e_raddr), .rd_data(e_rdata));

   cbsp_node_mem #(.NODE_COUNT(NODE_COUNT)) u_node (
      .clock(clock), .wr_en(n_wr), .wr_addr(n_waddr), .wr_data(n_wdata),
      .rd_addr(n_raddr), .rd_data(n_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         start_node_ff <= '0;
         max_cost_ff   <= DIST_MAX;
         edge_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         out_valid_ff  <= out_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_START_NODE: start_node_ff <= csr_data[NODE_W-1:0];
               CSR_MAX_COST:   max_cost_ff   <= csr_data;
               default: ;
            endcase
         end
      end
      eidx_ff <= eidx_in;
      nidx_ff <= nidx_in;
      rd_pend_ff <= rd_pend_in;
      found_ff <= found_in;
      best_ff <= best_in;
      bd_ff <= bd_in;
      tgt_ff <= tgt_in;
      sum_ff <= sum_in;
      out_id_ff <= out_id_in;
      out_rec_ff <= out_rec_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in = state_ff;
      edge_count_in = edge_count_ff;
      eidx_in = eidx_ff;
      nidx_in = nidx_ff;
      rd_pend_in = 1'b0;
      found_in = found_ff;
      best_in = best_ff;
      bd_in = bd_ff;
      tgt_in = tgt_ff;
      sum_in = sum_ff;
      out_valid_in = 1'b0;
      out_id_in = out_id_ff;
      out_rec_in = out_rec_ff;
      out_last_in = 1'b0;
      e_raddr = AW'(eidx_ff);
      n_wr = 1'b0;
      n_waddr = NODE_W'(nidx_ff);
      n_wdata = '{distance: DIST_MAX, prev: '0, has_prev: 1'b0, reached: 1'b0,
                  settled: 1'b0};
      n_raddr = NODE_W'(nidx_ff);
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (edge_count_ff < CAP) edge_count_in = edge_count_ff + CW'(1);
               if (req_last_edge) begin
                  state_in = ST_CLEAR;
                  nidx_in = '0;
               end
            end
         end
         ST_CLEAR: begin
            n_wr = 1'b1;
            if (NODE_W'(nidx_ff) == start_node_ff) n_wdata.distance = '0;
            nidx_in = nidx_ff + NW'(1);
            if (nidx_ff == NCNT - NW'(1)) begin
               nidx_in = '0;
               found_in = 1'b0;
               // out-of-range start: skip search
               state_in = ({{(NW-NODE_W){1'b0}}, start_node_ff} < NCNT) ?
                          ST_SELECT : ST_EMIT;
               rd_pend_in = 1'b0;
            end
         end
         ST_SELECT: begin
            // read node i, evaluate it in the next cycle
            if (rd_pend_ff && front && (!found_ff || n_rdata.distance < bd_ff)) begin
               found_in = 1'b1;
               best_in = prev_n;
               bd_in = n_rdata.distance;
            end
            if (nidx_ff == NCNT) begin
               nidx_in = '0;
               if (!found_in || bd_in >= max_cost_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  n_raddr = best_in;
                  state_in = ST_SCAN;
                  eidx_in = '0;
               end
            end else begin
               nidx_in = nidx_ff + NW'(1);
               rd_pend_in = 1'b1;
            end
         end
         ST_SCAN: begin
            // first cycle after select: n_rdata is the best node; mark settled
            if (!rd_pend_ff && eidx_ff == '0 && found_ff) begin
               n_wr = 1'b1;
               n_waddr = best_ff;
               n_wdata = n_rdata;
               n_wdata.settled = 1'b1;
               found_in = 1'b0;
               rd_pend_in = 1'b0;
            end else if (!rd_pend_ff) begin
               // issue edge read
               if (eidx_ff >= edge_count_ff) begin
                  state_in = ST_SELECT;
                  nidx_in = '0;
                  found_in = 1'b0;
               end else begin
                  e_raddr = AW'(eidx_ff);
                  rd_pend_in = 1'b1;
               end
            end else begin
               // edge data valid: read target node if the edge leaves the best node
               eidx_in = eidx_ff + CW'(1);
               if (e_src == best_ff && {{(NW-NODE_W){1'b0}}, e_tgt} < NCNT) begin
                  n_raddr = e_tgt;
                  tgt_in = e_tgt;
                  sum_in = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
                  state_in = ST_RELAX;
               end
            end
         end
         ST_RELAX: begin
            if (!n_rdata.settled && sum_ff <= n_rdata.distance) begin
               n_wr = 1'b1;
               n_waddr = tgt_ff;
               n_wdata = '{distance: sum_ff, prev: best_ff, has_prev: 1'b1,
                           reached: 1'b1, settled: 1'b0};
            end
            state_in = ST_SCAN;
         end
         ST_EMIT: begin
            if (rd_pend_ff) begin
               out_valid_in = 1'b1;
               out_id_in = prev_n;
               out_rec_in = n_rdata;
               out_last_in = (nidx_ff == NCNT);
            end
            if (nidx_ff == NCNT) begin
               state_in = ST_LOAD;
               edge_count_in = '0;
            end else begin
               nidx_in = nidx_ff + NW'(1);
               rd_pend_in = 1'b1;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // found_ff doubles as "settle pending" at scan entry
   assign rsp_valid         = out_valid_ff;
   assign rsp_node_id       = out_id_ff;
   assign rsp_best_cost     = out_rec_ff.distance;
   assign rsp_previous_node = out_rec_ff.has_prev ? out_rec_ff.prev : '0;
   assign rsp_has_previous  = out_rec_ff.has_prev;
   assign rsp_reached       = out_rec_ff.reached;
   assign rsp_last_result   = out_valid_ff && out_last_ff;
endmodule

// ===== sv/cbsp_edge_mem.sv =====
// Edge store: source, target and cost in one synchronous memory.
// Uses cbsp_pkg.
module cbsp_edge_mem import cbsp_pkg::*; #(
   parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF,
   parameter int AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [2*NODE_W+COST_W-1:0]   wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [2*NODE_W+COST_W-1:0]   rd_data
);
   logic [2*NODE_W+COST_W-1:0] mem [EDGE_CAPACITY];
   logic [2*NODE_W+COST_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ===== sv/cbsp_node_mem.sv =====
// Node state store: distance, predecessor and flags per node.
// One write port, one registered read port. Uses cbsp_pkg.
module cbsp_node_mem import cbsp_pkg::*; #(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [NODE_W-1:0] wr_addr,
   input  node_type          wr_data,
   input  logic [NODE_W-1:0] rd_addr,
   output node_type          rd_data
);
   node_type mem [NODE_COUNT];
   node_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ===== sv/cbsp_checker.sv =====
// Port-level checks for the cost bounded shortest path engine.
// Uses cbsp_pkg; bound to cost_bounded_shortest_paths.
module cbsp_checker import cbsp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic [NODE_W-1:0] rsp_node_id,
   input logic              rsp_last_result,
   input logic              rsp_has_previous,
   input logic [NODE_W-1:0] rsp_previous_node
);
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("result outside a run");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid && rsp_node_id == $past(rsp_node_id) + 1'b1)
      else $error("results not consecutive");
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_node_id == '0)
      else $error("first result not node zero");
   a_prev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_previous |-> rsp_previous_node == '0)
      else $error("predecessor without flag");
endmodule

bind cost_bounded_shortest_paths cbsp_checker u_cbsp_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_node_id(rsp_node_id), .rsp_last_result(rsp_last_result),
   .rsp_has_previous(rsp_has_previous), .rsp_previous_node(rsp_previous_node));
